// ===== design/paged_array_slot_manager_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PAGED_ARRAY_SLOT_MANAGER_ASSERT_SVH
`define PAGED_ARRAY_SLOT_MANAGER_ASSERT_SVH

// Property holds at every edge out of reset.
`define PASM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property violated");

// Antecedent at one edge implies consequent at the next.
`define PASM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle property violated");

`endif

// ===== design/pasm_pkg.sv =====
package pasm_pkg;

  localparam int unsigned NUM_SLOTS = 6;
  localparam int unsigned PAGE_SIZE = 256;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned OFF_W     = $clog2(PAGE_SIZE);
  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned CNT_W     = 16;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_MAX  = {CNT_W{1'b1}};
  localparam slot_t LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch a new word, restart the scan
    logic scan;     // examine one slot this cycle
    logic commit;   // update slot state and result register
  } pasm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // slot under scan is the last one
  } pasm_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_OUTPUT = 4'b1000
  } pasm_state_e;

endpackage

// ===== design/pasm_ctrl.sv =====
module pasm_ctrl import pasm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pasm_sts_t sts_i,
  output pasm_cmd_t cmd_o
);

  pasm_state_e state_q, state_d;

  // a new word may enter as the previous result leaves
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_OUTPUT) && out_ready_i);
  assign out_valid_o = (state_q == ST_OUTPUT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_ready_i) state_d = in_valid_i ? ST_SCAN : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.commit  = (state_q == ST_UPDATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/pasm_dp.sv =====
module pasm_dp import pasm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pasm_cmd_t cmd_i,
  output pasm_sts_t sts_o,
  input  idx_t      element_index_i,
  output logic      hit_o,
  output slot_t     slot_o,
  output off_t      offset_o,
  output page_t     load_page_o,
  output logic      evict_valid_o,
  output page_t     evict_page_o
);

  // slot state
  logic  valid_q [NUM_SLOTS];
  page_t tag_q   [NUM_SLOTS];
  cnt_t  cnt_q   [NUM_SLOTS];

  // current word
  page_t page_q;
  off_t  off_q;

  // scan state
  slot_t scan_idx_q;
  logic  hit_found_q, free_found_q;
  slot_t hit_slot_q, free_slot_q, best_slot_q;
  cnt_t  hit_cnt_q, best_cnt_q;
  page_t best_tag_q;

  logic  scan_valid;
  page_t scan_tag;
  cnt_t  scan_cnt;

  // commit decision
  slot_t sel_slot;
  cnt_t  sel_cnt;
  logic  do_load;

  assign sts_o.scan_last = (scan_idx_q == LAST_SLOT);

  assign scan_valid = valid_q[scan_idx_q];
  assign scan_tag   = tag_q[scan_idx_q];
  assign scan_cnt   = cnt_q[scan_idx_q];

  always_comb begin
    do_load = !hit_found_q;
    if (hit_found_q) begin
      sel_slot = hit_slot_q;
      sel_cnt  = (hit_cnt_q == CNT_MAX) ? CNT_MAX : hit_cnt_q + cnt_t'(1);
    end else if (free_found_q) begin
      sel_slot = free_slot_q;
      sel_cnt  = cnt_t'(1);
    end else begin
      sel_slot = best_slot_q;
      sel_cnt  = cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      scan_idx_q   <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + slot_t'(1);
      if (!hit_found_q && scan_valid && (scan_tag == page_q)) begin
        hit_found_q <= 1'b1;
      end
      if (!free_found_q && !scan_valid) begin
        free_found_q <= 1'b1;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q      <= element_index_i[OFF_W +: PAGE_W];
      off_q       <= element_index_i[OFF_W-1:0];
      best_slot_q <= '0;
      best_cnt_q  <= '0;
      best_tag_q  <= tag_q[0];
    end else if (cmd_i.scan) begin
      if (!hit_found_q && scan_valid && (scan_tag == page_q)) begin
        hit_slot_q <= scan_idx_q;
        hit_cnt_q  <= scan_cnt;
      end
      if (!free_found_q && !scan_valid) begin
        free_slot_q <= scan_idx_q;
      end
      if (scan_cnt > best_cnt_q) begin
        best_slot_q <= scan_idx_q;
        best_cnt_q  <= scan_cnt;
        best_tag_q  <= scan_tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        tag_q[i]   <= '0;
        cnt_q[i]   <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (sel_slot == slot_t'(i)) begin
          cnt_q[i] <= sel_cnt;
          if (do_load) begin
            valid_q[i] <= 1'b1;
            tag_q[i]   <= page_q;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= hit_found_q;
      slot_o        <= sel_slot;
      offset_o      <= off_q;
      load_page_o   <= do_load ? page_q : '0;
      evict_valid_o <= do_load && !free_found_q;
      evict_page_o  <= (do_load && !free_found_q) ? best_tag_q : '0;
    end
  end

endmodule

// ===== design/paged_array_slot_manager.sv =====
// Paged array slot manager.
// Input channel (in_valid_i/in_ready_o) carries one word: a 24-bit element
// index. The low 8 bits are the offset in a 256-element page, the upper 16
// bits the page number. Output channel (out_valid_o/out_ready_i) carries one
// result word per input word: hit flag, slot holding the page, offset, the
// page to load on a miss, and the evicted page needing write-back.
// Each accepted word is checked against the slots in turn, slot 0 first,
// in the scan state, then goes through the update state, which loads the
// result register, to the output state. A new word is taken only once the
// previous result leaves, since the single slot-scan loop is shared; it is
// accepted in the same cycle the previous result is taken.
// Stall: while out_valid_o is high and out_ready_i low the result holds and
// no new word is taken.
// Reset: all six slots free, use counts zero, both channels empty.
// Miss policy: lowest free slot, else slot with highest use count (lowest
// index on ties); counts restart on load and saturate at all-ones.
module paged_array_slot_manager import pasm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  idx_t  element_index_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  hit_o,
  output slot_t slot_o,
  output off_t  offset_o,
  output page_t load_page_o,
  output logic  evict_valid_o,
  output page_t evict_page_o
);

  pasm_cmd_t cmd;
  pasm_sts_t sts;

  // sequencer: idle / scan / update / output
  pasm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot table, scan registers and result register
  pasm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .element_index_i (element_index_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .offset_o        (offset_o),
    .load_page_o     (load_page_o),
    .evict_valid_o   (evict_valid_o),
    .evict_page_o    (evict_page_o)
  );

endmodule

// ===== design/pasm_checker.sv =====
`include "paged_array_slot_manager_assert.svh"

module pasm_checker import pasm_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input logic  hit_o,
  input slot_t slot_o,
  input off_t  offset_o,
  input page_t load_page_o,
  input logic  evict_valid_o,
  input page_t evict_page_o
);

  `PASM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(slot_o) && $stable(offset_o) && $stable(evict_page_o))
  `PASM_ASSERT(a_slot_range, clk_i, rst_ni, !out_valid_o || (slot_o < SLOT_W'(NUM_SLOTS)))
  `PASM_ASSERT(a_hit_clean, clk_i, rst_ni, !(out_valid_o && hit_o) || ((load_page_o == '0) && !evict_valid_o))
  `PASM_ASSERT(a_evict_zero, clk_i, rst_ni, !(out_valid_o && !evict_valid_o) || (evict_page_o == '0))
  `PASM_ASSERT_NEXT(a_no_early, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)

endmodule

bind paged_array_slot_manager pasm_checker u_pasm_checker (.*);
